// File: sv/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared types and constants of the periodic task dispatcher
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int unsigned SLOTS_DEF = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ID_W      = 3;
  localparam int unsigned MASK_W    = 8;

  // tdata widths of both stream sides, padded to whole bytes
  localparam int unsigned S_DATA_W  = 72;
  localparam int unsigned M_DATA_W  = 112;
  localparam int unsigned S_USER_W  = 2;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_SUSPEND = 2'd2,
    OP_RESUME  = 2'd3
  } ptd_op_e;

  // operation broadcast from the controller to every cell
  typedef struct packed {
    logic              exec;
    ptd_op_e           func;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   task_id;
  } ptd_op_t;

endpackage

// File: sv/ptd_cell.sv
// ----------------------------------------------------------------------------
// ptd_cell
// one task slot: period, last run, ready flag and run count; the slot
// allocation flag and the run count readout ripple along the row
// ----------------------------------------------------------------------------
module ptd_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptd_pkg::ptd_op_t             op_i,
  input  logic                         used_i,
  output logic                         used_o,
  input  logic [ptd_pkg::TIME_W-1:0]   rd_i,
  output logic [ptd_pkg::TIME_W-1:0]   rd_o,
  output logic                         due_o
);

  logic [ptd_pkg::TIME_W-1:0] period_q, period_d;
  logic [ptd_pkg::TIME_W-1:0] last_q, last_d;
  logic [ptd_pkg::TIME_W-1:0] runs_q, runs_d;
  logic                       ready_q, ready_d;
  logic                       used_q, used_d;
  logic [ptd_pkg::TIME_W-1:0] elapsed;
  logic                       sel;
  logic                       target;

  always_comb begin
    sel     = (32'(op_i.task_id) == INDEX);
    elapsed = op_i.now - last_q;
    due_o   = op_i.exec && (op_i.func == ptd_pkg::OP_TICK) &&
              used_q && ready_q && (elapsed >= period_q);
    // first free slot takes the add
    target  = used_i && !used_q;
    used_o  = used_q;
    rd_o    = rd_i | (sel ? runs_q : '0);
  end

  always_comb begin
    period_d = period_q;
    last_d   = last_q;
    runs_d   = runs_q;
    ready_d  = ready_q;
    used_d   = used_q;
    if (op_i.exec) begin
      unique case (op_i.func)
        ptd_pkg::OP_TICK: begin
          if (due_o) begin
            last_d = op_i.now;
            runs_d = runs_q + 32'd1;
          end
        end
        ptd_pkg::OP_ADD: begin
          if (target) begin
            period_d = op_i.period;
            last_d   = '0;
            runs_d   = '0;
            ready_d  = 1'b1;
            used_d   = 1'b1;
          end
        end
        ptd_pkg::OP_SUSPEND: begin
          if (sel && used_q) ready_d = 1'b0;
        end
        ptd_pkg::OP_RESUME: begin
          if (sel && used_q && !ready_q) begin
            ready_d = 1'b1;
            last_d  = op_i.now;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      runs_q  <= '0;
      ready_q <= 1'b0;
      used_q  <= 1'b0;
    end else begin
      last_q  <= last_d;
      runs_q  <= runs_d;
      ready_q <= ready_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
  end

endmodule

// File: sv/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// row of task slot cells driven by a small controller, one request at a time
// ----------------------------------------------------------------------------
//  channel  dir  handshake                   contents
//  s_axis   in   s_axis_tvalid/tready        tuser func, tdata now/period/task_id
//  m_axis   out  m_axis_tvalid/tready        tdata result fields
//
//  a request runs in steps: accept, slot update in every cell, run count
//  readout through the cell row into the output register
//  the readout ripple through SLOTS cells sets the length of the readout cycle
//  reset clears all slots to unused and suspended and zeroes the counters
//  a stalled result holds in the output register; the next request is
//  accepted meanwhile and waits in its readout cycle until the register frees
module periodic_task_dispatcher #(
  parameter int unsigned SLOTS = ptd_pkg::SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] now, [63:32] period, [66:64] task_id
  input  logic [ptd_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [ptd_pkg::S_USER_W-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] due_mask, [8] idle_pass, [11:9] new_task_id, [12] add_failed,
  // [44:13] run_count, [76:45] pass_count, [108:77] idle_count
  output logic [ptd_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]                  state_q, state_d;
  ptd_pkg::ptd_op_t            op;
  ptd_pkg::ptd_op_e            func_q;
  logic [ptd_pkg::TIME_W-1:0]  now_q, period_q;
  logic [ptd_pkg::ID_W-1:0]    id_q;
  logic [CNT_W-1:0]            used_cnt_q;
  logic [ptd_pkg::TIME_W-1:0]  pass_q, idle_cnt_q;
  logic [ptd_pkg::MASK_W-1:0]  due_q;
  logic                        idle_q, fail_q;
  logic [ptd_pkg::ID_W-1:0]    new_id_q;
  logic                        out_valid_q;
  logic [ptd_pkg::M_DATA_W-1:0] out_data_q;

  logic [SLOTS:0]              used_c;
  logic [ptd_pkg::TIME_W-1:0]  rd_c [SLOTS+1];
  logic [SLOTS-1:0]            due_c;
  logic [ptd_pkg::MASK_W-1:0]  due8;
  logic                        full;
  logic                        accept, out_free;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = used_c[SLOTS];
  assign used_c[0]     = 1'b1;
  assign rd_c[0]       = '0;

  assign op.exec    = (state_q == ST_EXEC);
  assign op.func    = func_q;
  assign op.now     = now_q;
  assign op.period  = period_q;
  assign op.task_id = id_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ptd_cell #(.INDEX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .used_i (used_c[g]),
      .used_o (used_c[g+1]),
      .rd_i   (rd_c[g]),
      .rd_o   (rd_c[g+1]),
      .due_o  (due_c[g])
    );
  end

  // only the first eight slots show in the mask
  for (genvar b = 0; b < ptd_pkg::MASK_W; b++) begin : g_mask
    if (b < SLOTS) begin : g_on
      assign due8[b] = due_c[b];
    end else begin : g_off
      assign due8[b] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_READ;
      ST_READ: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= ptd_pkg::ptd_op_e'(s_axis_tuser);
      now_q    <= s_axis_tdata[31:0];
      period_q <= s_axis_tdata[63:32];
      id_q     <= s_axis_tdata[66:64];
    end
    if (state_q == ST_EXEC) begin
      due_q    <= (func_q == ptd_pkg::OP_TICK) ? due8 : '0;
      idle_q   <= (func_q == ptd_pkg::OP_TICK) && (due_c == '0);
      fail_q   <= (func_q == ptd_pkg::OP_ADD) && full;
      new_id_q <= ((func_q == ptd_pkg::OP_ADD) && !full) ? 3'(used_cnt_q) : '0;
    end
    if (state_q == ST_READ && out_free) begin
      out_data_q <= {3'b000, idle_cnt_q, pass_q, rd_c[SLOTS], fail_q, new_id_q,
                     idle_q, due_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_cnt_q  <= '0;
      pass_q      <= '0;
      idle_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EXEC) begin
        if (func_q == ptd_pkg::OP_TICK) begin
          pass_q <= pass_q + 32'd1;
          if (due_c == '0) idle_cnt_q <= idle_cnt_q + 32'd1;
        end
        if (func_q == ptd_pkg::OP_ADD && !full) used_cnt_q <= used_cnt_q + CNT_W'(1);
      end
      if (state_q == ST_READ && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// port level checks of the periodic task dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module ptd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ptd_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a request keeps the block busy for its update cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted back to back");

  // an idle pass dispatches nothing
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("idle pass with due slots");

  // a failed add assigns no slot and dispatches nothing
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |->
      m_axis_tdata[11:9] == 3'd0 && m_axis_tdata[8:0] == 9'd0)
    else $error("failed add reports a slot");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
